// File: rtl/ipv4dq_pkg.sv
// Package for the IPv4 dotted-quad recognizer: beat types, verdict codes
// and character constants. It depends on nothing else.
package ipv4dq_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} item_t;

	typedef struct packed {
		logic       matched;
		logic [3:0] match_length;
	} result_t;

	typedef enum logic [1:0] {
		VERDICT_UNDECIDED = 2'd0,
		VERDICT_MATCHED   = 2'd1,
		VERDICT_FAILED    = 2'd2
	} verdict_t;

	localparam logic [7:0] CHAR_DOT        = 8'h2E;
	localparam logic [7:0] CHAR_ZERO       = 8'h30;
	localparam logic [7:0] CHAR_NINE       = 8'h39;
	localparam logic [8:0] TWO_DIGIT_LIMIT = 9'd25;
	localparam logic [8:0] OCTET_MAX       = 9'd255;
	localparam logic [1:0] LAST_OCTET      = 2'd3;
	localparam logic [3:0] MIN_ADDR_LENGTH = 4'd7;

endpackage

// File: rtl/ipv4_dotted_quad_recognizer.sv
// Top level of the IPv4 dotted-quad recognizer: input register, per-byte
// parse logic and result register. It depends on ipv4dq_pkg.
//
// A final byte goes through the input register and then the result register, where its result becomes valid.
// Throughput: one byte per cycle; the input register and the result register
// keep the two sides apart, so a stalled result holds back only a final byte.
// Reset clears the parse state and both valid flags at once; no clearing pass.
module ipv4_dotted_quad_recognizer
	import ipv4dq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic       s1_valid_s1;
	item_t      s1_item_s1;

	logic [1:0] octet_index_q;
	logic [1:0] digits_q;
	logic [8:0] value_q;
	logic       awaiting_dot_q;
	logic [3:0] consumed_q;
	verdict_t   verdict_q;

	logic       result_valid_q;
	result_t    result_q;

	logic       advance;
	logic       is_digit;
	logic [8:0] digit;
	logic [8:0] value_next10;
	logic       octet_end;
	logic       sep;

	logic [1:0] nxt_index;
	logic [1:0] nxt_digits;
	logic [8:0] nxt_value;
	logic       nxt_await;
	logic [3:0] nxt_consumed;
	verdict_t   nxt_verdict;
	verdict_t   fin_verdict;

	assign advance    = s1_valid_s1 && !(s1_item_s1.last && result_valid_q && result_stall);
	assign item_stall = s1_valid_s1 && !advance;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		is_digit     = (s1_item_s1.ch >= CHAR_ZERO) && (s1_item_s1.ch <= CHAR_NINE);
		digit        = is_digit ? {1'b0, s1_item_s1.ch - CHAR_ZERO} : 9'd0;
		value_next10 = (value_q << 3) + (value_q << 1) + digit;
		nxt_index    = octet_index_q;
		nxt_digits   = digits_q;
		nxt_value    = value_q;
		nxt_await    = awaiting_dot_q;
		nxt_consumed = consumed_q;
		nxt_verdict  = verdict_q;
		octet_end    = 1'b0;
		sep          = 1'b0;

		if (verdict_q == VERDICT_UNDECIDED) begin
			if (awaiting_dot_q) begin
				sep = 1'b1;
			end else if (digits_q == 2'd0) begin
				if (!is_digit) begin
					nxt_verdict = VERDICT_FAILED;
				end else begin
					nxt_consumed = consumed_q + 4'd1;
					nxt_value    = digit;
					nxt_digits   = 2'd1;
					octet_end    = (digit == 9'd0);
				end
			end else if (!is_digit) begin
				if (octet_index_q == LAST_OCTET) begin
					nxt_verdict = VERDICT_MATCHED;
				end else begin
					sep = 1'b1;
				end
			end else begin
				nxt_consumed = consumed_q + 4'd1;
				nxt_value    = value_next10;
				if (digits_q == 2'd1) begin
					nxt_digits = 2'd2;
					octet_end  = (value_next10 > TWO_DIGIT_LIMIT);
				end else begin
					nxt_digits = 2'd3;
					if (value_next10 > OCTET_MAX) begin
						nxt_verdict = VERDICT_FAILED;
					end else begin
						octet_end = 1'b1;
					end
				end
			end
		end

		if (octet_end) begin
			if (octet_index_q == LAST_OCTET) begin
				nxt_verdict = VERDICT_MATCHED;
			end else begin
				nxt_await = 1'b1;
			end
		end

		if (sep) begin
			if (s1_item_s1.ch == CHAR_DOT) begin
				nxt_consumed = consumed_q + 4'd1;
				nxt_index    = octet_index_q + 2'd1;
				nxt_await    = 1'b0;
				nxt_digits   = 2'd0;
				nxt_value    = 9'd0;
			end else begin
				nxt_verdict = VERDICT_FAILED;
			end
		end

		fin_verdict = nxt_verdict;
		if (nxt_verdict == VERDICT_UNDECIDED && nxt_index == LAST_OCTET &&
		    !nxt_await && nxt_digits != 2'd0) begin
			fin_verdict = VERDICT_MATCHED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			s1_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			s1_item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octet_index_q  <= 2'd0;
			digits_q       <= 2'd0;
			value_q        <= 9'd0;
			awaiting_dot_q <= 1'b0;
			consumed_q     <= 4'd0;
			verdict_q      <= VERDICT_UNDECIDED;
		end else if (advance) begin
			if (s1_item_s1.last) begin
				octet_index_q  <= 2'd0;
				digits_q       <= 2'd0;
				value_q        <= 9'd0;
				awaiting_dot_q <= 1'b0;
				consumed_q     <= 4'd0;
				verdict_q      <= VERDICT_UNDECIDED;
			end else begin
				octet_index_q  <= nxt_index;
				digits_q       <= nxt_digits;
				value_q        <= nxt_value;
				awaiting_dot_q <= nxt_await;
				consumed_q     <= nxt_consumed;
				verdict_q      <= nxt_verdict;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && s1_item_s1.last) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_item_s1.last) begin
			result_q.matched      <= (fin_verdict == VERDICT_MATCHED);
			result_q.match_length <= (fin_verdict == VERDICT_MATCHED) ? nxt_consumed : 4'd0;
		end
	end

`ifndef ASSERT_OFF
	// A failed string reports a length of zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.matched |-> result.match_length == 4'd0)
		else $error("unmatched result carries a nonzero length");

	// The shortest address has four digits and three dots.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.matched |-> result.match_length >= MIN_ADDR_LENGTH)
		else $error("matched result is shorter than any address");

	// A fresh octet has no value yet.
	assert property (@(posedge clk) disable iff (!arst_n)
		digits_q == 2'd0 |-> value_q == 9'd0)
		else $error("octet value set with no digits taken");

	// The fourth octet never waits for a dot.
	assert property (@(posedge clk) disable iff (!arst_n)
		awaiting_dot_q |-> octet_index_q != LAST_OCTET)
		else $error("dot awaited after the last octet");

	// Only a final byte facing a full, stalled result register stalls the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> s1_valid_s1 && s1_item_s1.last && result_valid_q && result_stall)
		else $error("input stalled without cause");
`endif

endmodule

// File: test/ipv4dq_checker.sv
// Checker for the IPv4 dotted-quad recognizer: watches both channels, predicts each
// string's verdict byte by byte and compares it with the result beats.
// It depends on ipv4dq_pkg.
module ipv4dq_checker
	import ipv4dq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_stall,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result,
	output int      errors,
	output int      pending
);

	logic [1:0] octet_no;
	logic [1:0] digit_count;
	logic [8:0] octet_val;
	logic       need_dot;
	logic [3:0] taken;
	verdict_t   outcome;
	result_t    verdicts_due[$];
	result_t    due;

	task clear_parse();
		octet_no = '0;
		digit_count = '0;
		octet_val = '0;
		need_dot = 1'b0;
		taken = '0;
		outcome = VERDICT_UNDECIDED;
	endtask

	task close_octet();
		if (octet_no == LAST_OCTET) begin
			outcome = VERDICT_MATCHED;
		end else begin
			need_dot = 1'b1;
		end
	endtask

	task take_separator(input logic [7:0] c);
		if (c == CHAR_DOT) begin
			taken = taken + 4'd1;
			octet_no = octet_no + 2'd1;
			need_dot = 1'b0;
			digit_count = '0;
			octet_val = '0;
		end else begin
			outcome = VERDICT_FAILED;
		end
	endtask

	task recognize_byte(input item_t beat);
		logic       is_digit;
		logic [8:0] digit;
		result_t    res;
		is_digit = beat.ch >= CHAR_ZERO && beat.ch <= CHAR_NINE;
		digit = is_digit ? {1'b0, beat.ch - CHAR_ZERO} : '0;
		if (outcome == VERDICT_UNDECIDED) begin
			if (need_dot) begin
				take_separator(beat.ch);
			end else if (digit_count == 2'd0) begin
				if (!is_digit) begin
					outcome = VERDICT_FAILED;
				end else begin
					taken = taken + 4'd1;
					octet_val = digit;
					digit_count = 2'd1;
					if (digit == 9'd0) close_octet();
				end
			end else if (!is_digit) begin
				// A short octet ends here; the byte itself is judged as what follows it.
				if (octet_no == LAST_OCTET) begin
					outcome = VERDICT_MATCHED;
				end else begin
					take_separator(beat.ch);
				end
			end else begin
				taken = taken + 4'd1;
				octet_val = octet_val * 9'd10 + digit;
				if (digit_count == 2'd1) begin
					digit_count = 2'd2;
					if (octet_val > TWO_DIGIT_LIMIT) close_octet();
				end else begin
					digit_count = 2'd3;
					if (octet_val > OCTET_MAX) begin
						outcome = VERDICT_FAILED;
					end else begin
						close_octet();
					end
				end
			end
		end
		if (beat.last) begin
			if (outcome == VERDICT_UNDECIDED && octet_no == LAST_OCTET && !need_dot &&
					digit_count != 2'd0) begin
				outcome = VERDICT_MATCHED;
			end
			res.matched = outcome == VERDICT_MATCHED;
			res.match_length = res.matched ? taken : 4'd0;
			verdicts_due.push_back(res);
			clear_parse();
		end
	endtask

	task flag_error(input string msg);
		errors++;
		if (errors <= 10) $display("mismatch at %0t: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			verdicts_due.delete();
			errors = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (verdicts_due.size() == 0) begin
					flag_error($sformatf("unexpected result beat matched=%b length=%0d",
						result.matched, result.match_length));
				end else begin
					due = verdicts_due.pop_front();
					if (result.matched !== due.matched ||
							result.match_length !== due.match_length) begin
						flag_error($sformatf("expected matched=%b length=%0d, got matched=%b length=%0d",
							due.matched, due.match_length, result.matched, result.match_length));
					end
				end
			end
			if (item_valid && !item_stall) recognize_byte(item);
		end
		pending = verdicts_due.size();
	end

endmodule

// File: test/testbench.sv
// Top of the testbench for the IPv4 dotted-quad recognizer: clock, reset, string
// stimulus with bursty sending and result stalls, watchdog and verdict.
// It depends on ipv4dq_pkg, ipv4_dotted_quad_recognizer and ipv4dq_checker.
module testbench;
	import ipv4dq_pkg::*;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_RUNS
	} stall_mode_t;

	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_BYTES = 920;
	localparam int N_DIRECTED   = 20;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;
	int      errors;
	int      pending;

	int          burst_left = 0;
	int          idle_cycles = 0;
	int          random_bytes_sent = 0;
	bit          paused = 1'b0;
	logic [7:0]  text_q[$];
	stall_mode_t stall_mode;
	int          stall_hold;
	logic        stall_level;

	string directed [N_DIRECTED] = '{
		"0.0.0.0", "255.255.255.255", "256.1.1.1", "1.2.3.4x", "26.1.1.1",
		"261.1.1.1", "01.1.1.1", "1.2.3", "1.2.3.", "1.2.3.25",
		"1.2.3.4.5", "1..1.1", "1.2.3.255", "192.168.1.100", "9/8:7.6.5",
		".1.2.3", "25.250.2.99", "1.2.3.256", "1.2.3.26x", "7"
	};

	ipv4_dotted_quad_recognizer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	ipv4dq_checker verdict_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task send_beat(input item_t beat);
		item <= beat;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 10);
		end else begin
			burst_left--;
		end
	endtask

	task send_text();
		foreach (text_q[i]) send_beat(item_t'({text_q[i], i == text_q.size() - 1}));
		text_q.delete();
	endtask

	task add_text(input string s);
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endtask

	task wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task add_random_string();
		int    kind;
		int    v;
		int    keep;
		string s;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 16)) text_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			s = "";
			for (int o = 0; o < 4; o++) begin
				case ($urandom_range(0, 7))
					0: v = 0;
					1: v = $urandom_range(1, 9);
					2: v = $urandom_range(10, 99);
					6: v = $urandom_range(256, 999);
					default: v = $urandom_range(100, 255);
				endcase
				if ($urandom_range(0, 11) == 0) begin
					s = {s, $sformatf("0%0d", v % 10)};
				end else begin
					s = {s, $sformatf("%0d", v)};
				end
				if (o < 3) s = {s, "."};
			end
			add_text(s);
			if ($urandom_range(0, 7) == 0) begin
				keep = $urandom_range(1, text_q.size());
				while (text_q.size() > keep) text_q.delete(text_q.size() - 1);
			end
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 2))
					0: text_q[$urandom_range(0, text_q.size() - 1)] = CHAR_DOT;
					1: text_q[$urandom_range(0, text_q.size() - 1)] =
						CHAR_ZERO + 8'($urandom_range(0, 9));
					default: text_q[$urandom_range(0, text_q.size() - 1)] =
						8'($urandom_range(0, 255));
				endcase
			end
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			add_text(directed[i]);
			send_text();
		end
		text_q.push_back(8'h00);
		send_text();
		text_q.push_back(8'hFF);
		add_text("1.1.1.1");
		send_text();
		add_text("10.0.0.9");
		text_q.push_back(8'h00);
		send_text();
		wait_drained();

		while (random_bytes_sent < RANDOM_BYTES) begin
			add_random_string();
			random_bytes_sent += text_q.size();
			if (!paused && random_bytes_sent > RANDOM_BYTES / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			send_text();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending != 0) $display("%0d expected results never arrived", pending);
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		result_stall <= 1'b0;
		stall_level = 1'b0;
		stall_hold = 0;
		forever begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			repeat ($urandom_range(30, 200)) begin
				@(posedge clk);
				case (stall_mode)
					STALL_NONE: result_stall <= 1'b0;
					STALL_LIGHT: result_stall <= $urandom_range(0, 3) == 0;
					STALL_HEAVY: result_stall <= $urandom_range(0, 3) != 0;
					default: begin
						if (stall_hold == 0) begin
							stall_level = ~stall_level;
							stall_hold = $urandom_range(1, 15);
						end
						stall_hold--;
						result_stall <= stall_level;
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule
